@@ rtl/core/assert_macros.svh @@
// Assertion helper macros for the text cursor block.
// Pulled in by the top level; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PS2_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication checked outside reset.
`define PS2_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ps2mtc_pkg.sv @@
// Shared constants, types and helpers for the PS/2 mouse text cursor block.
// No dependencies; used by the top level and the testbench.
package ps2mtc_pkg;

    // Default geometry
    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int STORE_DEPTH_DEF = 2048;

    // Field widths
    localparam int CELL_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int IDX_OUT_W = 11;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 6;
    localparam int ROW_OUT_W = 5;
    localparam int BTN_W     = 3;
    localparam int DELTA_W   = 6;
    localparam int SUM_W     = 9;
    localparam int MAG_W     = 9;

    // Cell contents and reset values
    localparam logic [CELL_W-1:0] BLANK_CELL       = 16'h0720;
    localparam logic [CELL_W-1:0] CURSOR_CELL      = 16'h7020;
    localparam logic [BYTE_W-1:0] RIGHT_ATTR       = 8'h40;
    localparam logic [BYTE_W-1:0] PAINT_RESET      = 8'hE0;
    localparam logic [COL_W-1:0]  CURSOR_COL_RESET = 7'd40;
    localparam logic [ROW_W-1:0]  CURSOR_ROW_RESET = 6'd12;

    // Header byte bit positions
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam int BTN_LEFT      = 0;
    localparam int BTN_RIGHT     = 1;

    // Divide by ten through multiply by reciprocal, exact for magnitudes up to 1028
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;

    // Result queue
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_FIFO_AW    = 2;

    // Input op codes
    localparam logic OP_MOUSE = 1'b0;
    localparam logic OP_HOST  = 1'b1;

    // Packet byte position
    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_X    = 3'b010,
        PH_Y    = 3'b100
    } t_pkt_phase;

    // Cell store access step for a packet
    typedef enum logic [1:0] {
        M_RD = 2'b01,
        M_WB = 2'b10
    } t_mem_state;

    typedef enum logic {
        K_HOST,
        K_PACKET
    } t_kind;

    // One result item
    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [CELL_W-1:0]    val;
        logic                 last;
        logic [COL_W-1:0]     col;
        logic [ROW_OUT_W-1:0] row;
        logic [BTN_W-1:0]     btn;
    } t_result;

    // 9-bit two's-complement movement divided by ten, truncating toward zero
    function automatic logic signed [DELTA_W-1:0] delta_div10(
        input logic              sign,
        input logic [BYTE_W-1:0] mv
    );
        logic [MAG_W-1:0]        mag;
        logic [MAG_W+BYTE_W-1:0] prod;
        logic [DELTA_W-1:0]      q;
        logic [DELTA_W-1:0]      q_s;
        mag  = sign ? (MAG_W'(256) - {1'b0, mv}) : {1'b0, mv};
        prod = (MAG_W + BYTE_W)'(mag) * (MAG_W + BYTE_W)'(DIV10_MUL);
        q    = DELTA_W'(prod >> DIV10_SHIFT);
        q_s  = sign ? (~q + 1'b1) : q;
        return $signed(q_s);
    endfunction

endpackage

@@ rtl/core/ps2mtc_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read.
// Read during write to the same address returns the old contents.
module ps2mtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ps2_mouse_text_cursor.sv @@
// PS/2 mouse packet decoder driving a text-mode pointer in a cell store.
// Uses ps2mtc_pkg, ps2mtc_ram and assert_macros.svh.
//
// Input channel (i_in_valid/o_in_ready): one item is either a raw mouse byte
// (i_op = 0) or a host write of one text cell (i_op = 1). Output channel
// (o_out_valid/i_out_ready): each cell write goes out as one result item;
// o_last marks the final write caused by an input item. A packet end with
// no left or right button gives two results (restore old cell, draw cursor),
// with either one result; an in-range host write one; other items none.
// Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_data): paint
// attribute for left clicks, ready outside reset.
// Path: an accepted item passes the input register, clamp, cell index,
// quotient and remainder stages, then the cell store stage; for a packet
// end with left or right held its only result comes from the write-back step.
// Throughput: one item per cycle while the cell store stage is not held; a
// packet end holds the cell store stage for a read step, then a write-back.
// Reset: the cell store is swept to blanks, one entry per cycle, over all
// STORE_DEPTH entries; no input item is taken until the sweep ends.
// Stall: results collect in a 4-entry queue; when it fills, the cell store
// stage holds and the pipeline and input stop.
`include "assert_macros.svh"

module ps2_mouse_text_cursor #(
    parameter int COLUMNS     = ps2mtc_pkg::COLUMNS_DEF,
    parameter int ROWS        = ps2mtc_pkg::ROWS_DEF,
    parameter int STORE_DEPTH = ps2mtc_pkg::STORE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [ps2mtc_pkg::BYTE_W-1:0]       i_mouse_byte,
    input  logic [ps2mtc_pkg::IDX_OUT_W-1:0]    i_host_cell_index,
    input  logic [ps2mtc_pkg::CELL_W-1:0]       i_host_cell_value,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ps2mtc_pkg::IDX_OUT_W-1:0]    o_write_index,
    output logic [ps2mtc_pkg::CELL_W-1:0]       o_write_value,
    output logic                                o_last,
    output logic [ps2mtc_pkg::COL_W-1:0]        o_pointer_column,
    output logic [ps2mtc_pkg::ROW_OUT_W-1:0]    o_pointer_row,
    output logic [ps2mtc_pkg::BTN_W-1:0]        o_buttons,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ps2mtc_pkg::BYTE_W-1:0]       i_cfg_data
);

    localparam int IW    = $clog2(STORE_DEPTH);
    localparam int LW    = $clog2(COLUMNS * ROWS);
    localparam int RECIP = (1 << LW) / STORE_DEPTH;

    // Item travelling down the pipeline
    typedef struct packed {
        logic                                   valid;
        ps2mtc_pkg::t_kind                      kind;
        logic [IW-1:0]                          idx;
        logic [ps2mtc_pkg::CELL_W-1:0]          val;
        logic signed [ps2mtc_pkg::DELTA_W-1:0]  dx;
        logic signed [ps2mtc_pkg::DELTA_W-1:0]  dy;
        logic [ps2mtc_pkg::BTN_W-1:0]           btn;
        logic [ps2mtc_pkg::COL_W-1:0]           col_old;
        logic [ps2mtc_pkg::ROW_W-1:0]           row_old;
        logic [ps2mtc_pkg::COL_W-1:0]           col;
        logic [ps2mtc_pkg::ROW_W-1:0]           row;
        logic [LW-1:0]                          lin;
        logic [LW-1:0]                          q;
    } t_item;

    // Packet assembly state
    ps2mtc_pkg::t_pkt_phase             r_phase;
    logic [ps2mtc_pkg::BYTE_W-1:0]      r_hdr;
    logic [ps2mtc_pkg::BYTE_W-1:0]      r_xbyte;
    logic [ps2mtc_pkg::BYTE_W-1:0]      r_paint;

    // Cursor state
    logic [ps2mtc_pkg::COL_W-1:0]       r_col;
    logic [ps2mtc_pkg::ROW_W-1:0]       r_row;
    logic [ps2mtc_pkg::BTN_W-1:0]       r_btn;
    logic [ps2mtc_pkg::CELL_W-1:0]      r_saved_cell;
    logic [IW-1:0]                      r_saved_idx;

    // Pipeline
    t_item r_s1, r_s2, r_s3, r_s4, r_m;
    t_item n_s1, n_s2, n_s3, n_s4, n_m;
    ps2mtc_pkg::t_mem_state r_m_st, n_m_st;
    logic  r_fwd;

    // Clear sweep
    logic          r_clr_busy;
    logic [IW-1:0] r_clr_addr;

    // Result queue
    ps2mtc_pkg::t_result               r_fifo [ps2mtc_pkg::OUT_FIFO_DEPTH];
    logic [ps2mtc_pkg::OUT_FIFO_AW-1:0] r_wr_ptr;
    logic [ps2mtc_pkg::OUT_FIFO_AW-1:0] r_rd_ptr;
    logic [ps2mtc_pkg::OUT_FIFO_AW:0]   r_cnt;

    // Cell store port
    logic                               w_mem_we;
    logic [IW-1:0]                      w_mem_waddr;
    logic [ps2mtc_pkg::CELL_W-1:0]      w_mem_wdata;
    logic [ps2mtc_pkg::CELL_W-1:0]      w_mem_rdata;
    logic                               w_st_we;
    logic [IW-1:0]                      w_st_waddr;
    logic [ps2mtc_pkg::CELL_W-1:0]      w_st_wdata;

    logic                               w_in_fire;
    logic                               w_host_ok;
    logic                               w_adv;
    logic                               w_room;
    logic                               w_m_go;
    logic                               w_m_done;
    logic                               w_restore;
    logic                               w_push;
    logic                               w_pop;
    ps2mtc_pkg::t_result                w_res;
    logic [ps2mtc_pkg::CELL_W-1:0]      w_cell;
    logic [ps2mtc_pkg::CELL_W-1:0]      w_new_val;
    logic signed [ps2mtc_pkg::SUM_W-1:0] w_col_sum;
    logic signed [ps2mtc_pkg::SUM_W-1:0] w_row_sum;
    logic [ps2mtc_pkg::COL_W-1:0]       w_col_new;
    logic [ps2mtc_pkg::ROW_W-1:0]       w_row_new;
    logic [2*LW-1:0]                    w_q_prod;
    logic [2*LW-1:0]                    w_qsd;
    logic [LW-1:0]                      w_rem;
    logic [LW-1:0]                      w_rem_c;

    // Handshakes
    assign w_room     = (r_cnt != (ps2mtc_pkg::OUT_FIFO_AW + 1)'(ps2mtc_pkg::OUT_FIFO_DEPTH));
    assign w_m_go     = r_m.valid && w_room;
    assign w_m_done   = w_m_go && ((r_m.kind == ps2mtc_pkg::K_HOST) || (r_m_st == ps2mtc_pkg::M_WB));
    assign w_adv      = !r_m.valid || w_m_done;
    assign o_in_ready = w_adv && !r_clr_busy;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_host_ok  = (32'(i_host_cell_index) < STORE_DEPTH);
    assign o_cfg_ready = i_rst_n;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paint <= ps2mtc_pkg::PAINT_RESET;
        end else if (i_cfg_valid) begin
            r_paint <= i_cfg_data;
        end
    end

    // Packet assembly: header must carry the sync bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ps2mtc_pkg::PH_HEAD;
            r_hdr   <= '0;
            r_xbyte <= '0;
        end else if (w_in_fire && (i_op == ps2mtc_pkg::OP_MOUSE)) begin
            unique case (r_phase)
                ps2mtc_pkg::PH_X: begin
                    r_xbyte <= i_mouse_byte;
                    r_phase <= ps2mtc_pkg::PH_Y;
                end
                ps2mtc_pkg::PH_Y: begin
                    r_phase <= ps2mtc_pkg::PH_HEAD;
                end
                default: begin
                    if (i_mouse_byte[ps2mtc_pkg::HDR_SYNC_BIT]) begin
                        r_hdr   <= i_mouse_byte;
                        r_phase <= ps2mtc_pkg::PH_X;
                    end else begin
                        r_phase <= ps2mtc_pkg::PH_HEAD;
                    end
                end
            endcase
        end
    end

    // Stage 1 load: host writes in range and completed packets
    always_comb begin
        n_s1       = '0;
        n_s1.valid = w_in_fire && ((i_op == ps2mtc_pkg::OP_HOST) ? w_host_ok
                                   : (r_phase == ps2mtc_pkg::PH_Y));
        n_s1.kind  = (i_op == ps2mtc_pkg::OP_HOST) ? ps2mtc_pkg::K_HOST
                                                   : ps2mtc_pkg::K_PACKET;
        n_s1.idx   = IW'(i_host_cell_index);
        n_s1.val   = i_host_cell_value;
        n_s1.dx    = ps2mtc_pkg::delta_div10(r_hdr[ps2mtc_pkg::HDR_XSIGN_BIT], r_xbyte);
        n_s1.dy    = ps2mtc_pkg::delta_div10(r_hdr[ps2mtc_pkg::HDR_YSIGN_BIT], i_mouse_byte);
        n_s1.btn   = r_hdr[ps2mtc_pkg::BTN_W-1:0];
    end

    // Stage 1: move and clamp the cursor (Y inverted)
    always_comb begin
        w_col_sum = $signed({2'b00, r_col})
                  + $signed({{(ps2mtc_pkg::SUM_W - ps2mtc_pkg::DELTA_W){r_s1.dx[ps2mtc_pkg::DELTA_W-1]}},
                             r_s1.dx});
        w_row_sum = $signed({3'b000, r_row})
                  - $signed({{(ps2mtc_pkg::SUM_W - ps2mtc_pkg::DELTA_W){r_s1.dy[ps2mtc_pkg::DELTA_W-1]}},
                             r_s1.dy});
        if (w_col_sum < 0) begin
            w_col_new = '0;
        end else if (w_col_sum > $signed(ps2mtc_pkg::SUM_W'(COLUMNS - 1))) begin
            w_col_new = ps2mtc_pkg::COL_W'(COLUMNS - 1);
        end else begin
            w_col_new = w_col_sum[ps2mtc_pkg::COL_W-1:0];
        end
        if (w_row_sum < 0) begin
            w_row_new = '0;
        end else if (w_row_sum > $signed(ps2mtc_pkg::SUM_W'(ROWS - 1))) begin
            w_row_new = ps2mtc_pkg::ROW_W'(ROWS - 1);
        end else begin
            w_row_new = w_row_sum[ps2mtc_pkg::ROW_W-1:0];
        end

        n_s2         = r_s1;
        n_s2.col_old = r_col;
        n_s2.row_old = r_row;
        if (r_s1.kind == ps2mtc_pkg::K_PACKET) begin
            n_s2.col = w_col_new;
            n_s2.row = w_row_new;
        end else begin
            n_s2.col = r_col;
            n_s2.row = r_row;
            n_s2.btn = r_btn;
        end
    end

    // Stage 2: linear cell index
    always_comb begin
        n_s3     = r_s2;
        n_s3.lin = LW'(32'(r_s2.row) * COLUMNS + 32'(r_s2.col));
    end

    // Stage 3: quotient estimate by reciprocal, may be one short
    always_comb begin
        w_q_prod = (2*LW)'(r_s3.lin) * (2*LW)'(RECIP);
        n_s4     = r_s3;
        n_s4.q   = w_q_prod[2*LW-1:LW];
    end

    // Stage 4: remainder with one correction step
    always_comb begin
        w_qsd   = (2*LW)'(r_s4.q) * (2*LW)'(STORE_DEPTH);
        w_rem   = r_s4.lin - w_qsd[LW-1:0];
        w_rem_c = (32'(w_rem) >= STORE_DEPTH) ? (w_rem - LW'(STORE_DEPTH)) : w_rem;
        n_m     = r_s4;
        if (r_s4.kind == ps2mtc_pkg::K_PACKET) begin
            n_m.idx = IW'(w_rem_c);
        end
    end

    // Pipeline registers and cursor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
            r_m.valid  <= 1'b0;
            r_col      <= ps2mtc_pkg::CURSOR_COL_RESET;
            r_row      <= ps2mtc_pkg::CURSOR_ROW_RESET;
            r_btn      <= '0;
        end else if (w_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_m  <= n_m;
            if (r_s1.valid && (r_s1.kind == ps2mtc_pkg::K_PACKET)) begin
                r_col <= w_col_new;
                r_row <= w_row_new;
                r_btn <= r_s1.btn;
            end
        end
    end

    function automatic logic [ps2mtc_pkg::IDX_OUT_W-1:0] IDX_OUT_W_CAST(input logic [IW-1:0] a);
        return ps2mtc_pkg::IDX_OUT_W'(a);
    endfunction

    // Cell store stage: restore/read, then write-back
    always_comb begin
        w_restore   = !r_m.btn[ps2mtc_pkg::BTN_LEFT] && !r_m.btn[ps2mtc_pkg::BTN_RIGHT];
        w_cell      = r_fwd ? r_saved_cell : w_mem_rdata;
        if (r_m.btn[ps2mtc_pkg::BTN_LEFT]) begin
            w_new_val = {r_paint, w_cell[ps2mtc_pkg::BYTE_W-1:0]};
        end else if (r_m.btn[ps2mtc_pkg::BTN_RIGHT]) begin
            w_new_val = {ps2mtc_pkg::RIGHT_ATTR, w_cell[ps2mtc_pkg::BYTE_W-1:0]};
        end else begin
            w_new_val = ps2mtc_pkg::CURSOR_CELL;
        end

        n_m_st      = r_m_st;
        w_st_we     = 1'b0;
        w_st_waddr  = r_m.idx;
        w_st_wdata  = w_new_val;
        w_push      = 1'b0;
        w_res.idx   = IDX_OUT_W_CAST(r_m.idx);
        w_res.val   = w_new_val;
        w_res.last  = 1'b1;
        w_res.col   = r_m.col;
        w_res.row   = ps2mtc_pkg::ROW_OUT_W'(r_m.row);
        w_res.btn   = r_m.btn;

        if (w_m_go) begin
            if (r_m.kind == ps2mtc_pkg::K_HOST) begin
                w_st_we    = 1'b1;
                w_st_wdata = r_m.val;
                w_push     = 1'b1;
                w_res.val  = r_m.val;
            end else begin
                unique case (r_m_st)
                    ps2mtc_pkg::M_RD: begin
                        n_m_st = ps2mtc_pkg::M_WB;
                        if (w_restore) begin
                            w_st_we    = 1'b1;
                            w_st_waddr = r_saved_idx;
                            w_st_wdata = r_saved_cell;
                            w_push     = 1'b1;
                            w_res.idx  = IDX_OUT_W_CAST(r_saved_idx);
                            w_res.val  = r_saved_cell;
                            w_res.last = 1'b0;
                            w_res.col  = r_m.col_old;
                            w_res.row  = ps2mtc_pkg::ROW_OUT_W'(r_m.row_old);
                        end
                    end
                    ps2mtc_pkg::M_WB: begin
                        n_m_st  = ps2mtc_pkg::M_RD;
                        w_st_we = 1'b1;
                        w_push  = 1'b1;
                    end
                    default: begin
                        n_m_st = ps2mtc_pkg::M_RD;
                    end
                endcase
            end
        end
    end

    // Memory step state and saved cell under the cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_st       <= ps2mtc_pkg::M_RD;
            r_fwd        <= 1'b0;
            r_saved_cell <= ps2mtc_pkg::BLANK_CELL;
            r_saved_idx  <= '0;
        end else begin
            r_m_st <= n_m_st;
            if (w_m_go && (r_m.kind == ps2mtc_pkg::K_PACKET)) begin
                if (r_m_st == ps2mtc_pkg::M_RD) begin
                    // restore write and read hit the same cell: read returns old data
                    r_fwd <= w_restore && (r_saved_idx == r_m.idx);
                end else if (w_restore) begin
                    r_saved_cell <= w_cell;
                    r_saved_idx  <= r_m.idx;
                end
            end
        end
    end

    // Clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IW'(STORE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Cell store write port: sweep or pipeline
    assign w_mem_we    = r_clr_busy || w_st_we;
    assign w_mem_waddr = r_clr_busy ? r_clr_addr : w_st_waddr;
    assign w_mem_wdata = r_clr_busy ? ps2mtc_pkg::BLANK_CELL : w_st_wdata;

    ps2mtc_ram #(
        .WIDTH (ps2mtc_pkg::CELL_W),
        .DEPTH (STORE_DEPTH)
    ) u_cell_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_m.idx),
        .o_rdata (w_mem_rdata)
    );

    // Result queue
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_fifo[r_wr_ptr] <= w_res;
                r_wr_ptr         <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_write_index    = r_fifo[r_rd_ptr].idx;
    assign o_write_value    = r_fifo[r_rd_ptr].val;
    assign o_last           = r_fifo[r_rd_ptr].last;
    assign o_pointer_column = r_fifo[r_rd_ptr].col;
    assign o_pointer_row    = r_fifo[r_rd_ptr].row;
    assign o_buttons        = r_fifo[r_rd_ptr].btn;

    // Checks
    `PS2_ASSERT_IMPLY(a_no_accept_in_sweep, i_clk, i_rst_n, r_clr_busy, !o_in_ready, "item taken during clear sweep")
    `PS2_ASSERT_IMPLY(a_sweep_idle_pipe, i_clk, i_rst_n, r_clr_busy, !r_m.valid && !w_st_we, "cell store stage active during clear sweep")
    `PS2_ASSERT_IMPLY(a_restore_only_in_read, i_clk, i_rst_n, w_push && !w_res.last, (r_m.kind == ps2mtc_pkg::K_PACKET) && (r_m_st == ps2mtc_pkg::M_RD), "non-final result outside packet read step")
    `PS2_ASSERT_IMPLY(a_cursor_on_screen, i_clk, i_rst_n, r_m.valid && (r_m.kind == ps2mtc_pkg::K_PACKET), (32'(r_m.col) < COLUMNS) && (32'(r_m.row) < ROWS), "cursor off screen at cell store")
    `PS2_ASSERT(a_queue_bound, i_clk, i_rst_n, 32'(r_cnt) <= ps2mtc_pkg::OUT_FIFO_DEPTH, "result queue overflow")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the PS/2 mouse text cursor block.
// Needs ps2mtc_pkg and ps2_mouse_text_cursor; a scoreboard class predicts every cell write.
module tb;
    import ps2mtc_pkg::*;

    localparam int NCOL   = COLUMNS_DEF;
    localparam int NROW   = ROWS_DEF;
    localparam int NCELLS = STORE_DEPTH_DEF;

    // Predicts cell writes from accepted items and checks the block's results
    class cell_write_board;
        logic [7:0]  paint;
        int          phase;
        logic [7:0]  header;
        logic [7:0]  x_move;
        int          col;
        int          row;
        logic [15:0] saved_cell;
        int          saved_col;
        int          saved_row;
        logic [2:0]  btn;
        logic [15:0] cells [NCELLS];
        t_result     want_q [$];
        int          errors;
        int          checked;
        int          n_packets, n_left, n_right, n_plain, n_host, n_dropped;

        function new();
            paint      = PAINT_RESET;
            phase      = 0;
            header     = '0;
            x_move     = '0;
            col        = 40;
            row        = 12;
            saved_cell = BLANK_CELL;
            saved_col  = 0;
            saved_row  = 0;
            btn        = '0;
            foreach (cells[i]) cells[i] = BLANK_CELL;
            errors = 0;
            checked = 0;
            n_packets = 0; n_left = 0; n_right = 0; n_plain = 0; n_host = 0; n_dropped = 0;
        endfunction

        function void set_paint(logic [7:0] v);
            paint = v;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function int cell_of(int c, int r);
            return (r * NCOL + c) % NCELLS;
        endfunction

        function int cursor_cell();
            return cell_of(col, row);
        endfunction

        function int saved_pos();
            return cell_of(saved_col, saved_row);
        endfunction

        // 9-bit two's-complement movement, divided by ten toward zero
        function int move_div10(logic sign, logic [7:0] mv);
            int v;
            v = mv;
            if (sign) v -= 256;
            return v / 10;
        endfunction

        // Cursor and buttons are taken as they stand at the moment of the write
        function void push_write(int idx, logic [15:0] val, logic lst);
            t_result w;
            w.idx  = idx[IDX_OUT_W-1:0];
            w.val  = val;
            w.last = lst;
            w.col  = col[COL_W-1:0];
            w.row  = row[ROW_OUT_W-1:0];
            w.btn  = btn;
            want_q.push_back(w);
        endfunction

        function void end_packet(logic [7:0] y_move);
            logic        left, right;
            int          c, r, idx;
            logic [15:0] val;
            btn   = header[2:0];
            left  = btn[BTN_LEFT];
            right = btn[BTN_RIGHT];
            n_packets++;
            // no click: put back the cell hidden under the old cursor
            if (!left && !right) begin
                idx = cell_of(saved_col, saved_row);
                cells[idx] = saved_cell;
                push_write(idx, saved_cell, 1'b0);
            end
            c = col + move_div10(header[HDR_XSIGN_BIT], x_move);
            r = row - move_div10(header[HDR_YSIGN_BIT], y_move);
            if (c < 0) c = 0;
            if (c > NCOL - 1) c = NCOL - 1;
            if (r < 0) r = 0;
            if (r > NROW - 1) r = NROW - 1;
            col = c;
            row = r;
            idx = cell_of(col, row);
            if (left) begin
                val = {paint, cells[idx][7:0]};
                n_left++;
            end else if (right) begin
                val = {RIGHT_ATTR, cells[idx][7:0]};
                n_right++;
            end else begin
                saved_cell = cells[idx];
                saved_col  = col;
                saved_row  = row;
                val        = CURSOR_CELL;
                n_plain++;
            end
            cells[idx] = val;
            push_write(idx, val, 1'b1);
        endfunction

        // Called once per accepted input item
        function void note_item(logic op, logic [7:0] mb, logic [10:0] hidx, logic [15:0] hval);
            if (op == OP_HOST) begin
                n_host++;
                if (int'(hidx) < NCELLS) begin
                    cells[hidx] = hval;
                    push_write(hidx, hval, 1'b1);
                end
                return;
            end
            case (phase)
                1: begin
                    x_move = mb;
                    phase  = 2;
                end
                2: begin
                    phase = 0;
                    end_packet(mb);
                end
                default: begin
                    if (mb[HDR_SYNC_BIT]) begin
                        header = mb;
                        phase  = 1;
                    end else begin
                        phase = 0;
                        n_dropped++;
                    end
                end
            endcase
        endfunction

        function void compare(string name, logic [15:0] exp, logic [15:0] act);
            if (act !== exp) begin
                $error("%s mismatch: expected %h, got %h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_write(t_result got);
            t_result want;
            if (want_q.size() == 0) begin
                $error("unexpected cell write: index %h value %h", got.idx, got.val);
                errors++;
                return;
            end
            want = want_q.pop_front();
            checked++;
            compare("write_index", want.idx, got.idx);
            compare("write_value", want.val, got.val);
            compare("last", want.last, got.last);
            compare("pointer_column", want.col, got.col);
            compare("pointer_row", want.row, got.row);
            compare("buttons", want.btn, got.btn);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_op = 1'b0;
    logic [7:0]  in_mb = '0;
    logic [10:0] in_idx = '0;
    logic [15:0] in_val = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data = '0;

    wire         in_ready;
    wire         out_valid;
    wire [10:0]  wr_index;
    wire [15:0]  wr_value;
    wire         wr_last;
    wire [6:0]   ptr_col;
    wire [4:0]   ptr_row;
    wire [2:0]   btn_out;
    wire         cfg_ready;

    cell_write_board sb;
    int          items_sent = 0;
    int          settings_used = 1;
    int          rx_mode = 0;
    int          stall_left = 0;
    bit          tx_gaps = 1'b0;
    int          burst_left = 1;
    t_result     got;

    ps2_mouse_text_cursor DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (in_op),
        .i_mouse_byte      (in_mb),
        .i_host_cell_index (in_idx),
        .i_host_cell_value (in_val),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_write_index     (wr_index),
        .o_write_value     (wr_value),
        .o_last            (wr_last),
        .o_pointer_column  (ptr_col),
        .o_pointer_row     (ptr_row),
        .o_buttons         (btn_out),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data)
    );

    // 12-unit clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: always ready, random stalls, or long stalls now and then
    always @(posedge clk) begin
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    out_ready  <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left <= $urandom_range(1, 16);
                    out_ready  <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            got.idx  = wr_index;
            got.val  = wr_value;
            got.last = wr_last;
            got.col  = ptr_col;
            got.row  = ptr_row;
            got.btn  = btn_out;
            sb.check_write(got);
        end
    end

    // Offer one item, wait for it to be taken, then maybe end the burst
    task automatic send_item(logic op, logic [7:0] mb, logic [10:0] hidx, logic [15:0] hval);
        int gap;
        in_valid <= 1'b1;
        in_op    <= op;
        in_mb    <= mb;
        in_idx   <= hidx;
        in_val   <= hval;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.note_item(op, mb, hidx, hval);
        items_sent++;
        if (tx_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic mouse(logic [7:0] mb);
        send_item(OP_MOUSE, mb, 11'($urandom), 16'($urandom));
    endtask

    task automatic host(int idx, logic [15:0] v);
        send_item(OP_HOST, 8'($urandom), idx[10:0], v);
    endtask

    // Host write, often aimed at the cursor or the hidden cell
    task automatic host_random();
        int pick;
        int idx;
        pick = $urandom_range(0, 9);
        if (pick < 3) idx = sb.cursor_cell();
        else if (pick == 3) idx = sb.saved_pos();
        else idx = $urandom_range(0, 1999);
        host(idx, 16'($urandom));
    endtask

    function automatic logic [7:0] move_byte(logic sign);
        int mag;
        if ($urandom_range(0, 1)) return 8'($urandom);
        mag = $urandom_range(0, 40);
        return sign ? 8'(256 - mag) : 8'(mag);
    endfunction

    // Well-formed packet, with host writes sometimes slipped between bytes
    task automatic send_packet(bit complete);
        logic [7:0] hdr;
        hdr[7:6] = 2'($urandom);
        hdr[5:4] = 2'($urandom);
        hdr[3]   = 1'b1;
        hdr[2:0] = $urandom_range(0, 1) ? 3'd0 : 3'($urandom);
        mouse(hdr);
        if ($urandom_range(0, 11) == 0) host_random();
        mouse(move_byte(hdr[HDR_XSIGN_BIT]));
        if (!complete) return;
        if ($urandom_range(0, 11) == 0) host_random();
        mouse(move_byte(hdr[HDR_YSIGN_BIT]));
    endtask

    task automatic random_traffic(int n);
        int stop_at;
        int pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) send_packet(1'b1);
            else if (pick < 84) host_random();
            else if (pick < 94) mouse(8'($urandom));
            else send_packet(1'b0);
        end
    endtask

    // Stop sending and let every expected write come out, plus pipeline slack
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_paint(logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.set_paint(v);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Run limit
    initial begin
        #12000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, each button case, sign and clamp corners
        host(0, 16'hFFFF);
        host(1999, 16'h0000);
        mouse(8'hF7);                                   // header without sync bit
        mouse(8'h08); mouse(8'hFF); mouse(8'hFF);       // big move up-right, row clamps
        mouse(8'h38); mouse(8'h00); mouse(8'h00);       // -256 both ways, row clamps low
        mouse(8'h09); mouse(8'h80); mouse(8'h01);       // left click
        mouse(8'h0A); mouse(8'h7F); mouse(8'h81);       // right click
        mouse(8'h0B); mouse(8'h05); mouse(8'h09);       // left beats right
        mouse(8'h0C); mouse(8'h40); mouse(8'hC0);       // middle alone is no press
        mouse(8'hFF); mouse(8'hFF); mouse(8'hF6);       // -1 truncates to 0, -10 to -1
        drain();

        write_paint(8'h00);
        rx_mode <= 1;
        tx_gaps = 1'b1;
        random_traffic(360);
        drain();

        write_paint(8'hFF);
        rx_mode <= 2;
        random_traffic(360);
        drain();

        write_paint(8'($urandom));
        rx_mode <= 0;
        tx_gaps = 1'b0;
        random_traffic(360);
        drain();

        write_paint(8'($urandom));
        rx_mode <= 2;
        random_traffic(360);
        drain();

        write_paint(8'($urandom));
        rx_mode <= 1;
        tx_gaps = 1'b1;
        random_traffic(360);
        drain();

        if (sb.pending() != 0) begin
            $error("%0d expected cell writes never arrived", sb.pending());
            sb.errors++;
        end
        $display("Sent %0d items: %0d packets (%0d left, %0d right, %0d no click), %0d host, %0d dropped",
                 items_sent, sb.n_packets, sb.n_left, sb.n_right, sb.n_plain, sb.n_host,
                 sb.n_dropped);
        $display("Checked %0d cell writes across %0d paint attribute settings",
                 sb.checked, settings_used);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
